### src/pic_pkg.sv
// Shared types, constants and codes of the platform interrupt controller.
package pic_pkg;

	localparam int NUM_SOURCES   = 64;
	localparam int NUM_CONTEXTS  = 4;
	localparam int PRIO_BITS     = 5;

	localparam int SRC_W     = $clog2(NUM_SOURCES);
	localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;
	localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int ADDR_W    = 26;

	localparam logic [31:0] PRIO_MAX = 32'((1 << PRIO_BITS) - 1);

	localparam logic [ADDR_W-1:0] PRIO_END   = ADDR_W'(NUM_SOURCES * 4);
	localparam logic [ADDR_W-1:0] PEND_BASE  = ADDR_W'(32'h1000);
	localparam logic [ADDR_W-1:0] PEND_END   = ADDR_W'(32'h1000 + SRC_WORDS * 4);
	localparam logic [ADDR_W-1:0] EN_BASE    = ADDR_W'(32'h2000);
	localparam logic [ADDR_W-1:0] EN_END     = ADDR_W'(32'h2000 + NUM_CONTEXTS * 32'h100);
	localparam logic [ADDR_W-1:0] CTRL_ADDR  = ADDR_W'(32'h1ffffc);
	localparam logic [ADDR_W-1:0] CTX_BASE   = ADDR_W'(32'h200000);
	localparam logic [ADDR_W-1:0] CTX_END    = ADDR_W'(32'h200000 + NUM_CONTEXTS * 32'h2000);
	localparam logic [12:0]       CLAIM_OFF  = 13'h004;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;
	localparam logic [1:0] CMD_RSVD    = 2'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] address;
		logic [31:0]       write_data;
		logic [5:0]        source_id;
		logic              level;
	} pic_cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_error;
		logic [3:0]  irq_lines;
	} pic_res_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_PRIO_RD,
		OP_PRIO_WR,
		OP_PEND_RD,
		OP_PEND_WR,
		OP_EN_RD,
		OP_EN_WR,
		OP_CTRL_RD,
		OP_CTRL_WR,
		OP_THR_RD,
		OP_THR_WR,
		OP_CLAIM,
		OP_COMPLETE,
		OP_REQ
	} pic_kind_t;

	typedef struct packed {
		pic_kind_t         kind;
		logic [SRC_W-1:0]  idx;
		logic [CTX_W-1:0]  ctx;
		logic [31:0]       data;
	} pic_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PRD,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} pic_state_t;

endpackage

### src/pic_front.sv
// Front end: decodes commands into operations and queues them for the back end.
module pic_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pic_pkg::pic_cmd_t item,
	output logic              busy,
	input  logic              pop,
	output pic_pkg::pic_op_t  head,
	output logic              empty
);
	import pic_pkg::*;

	pic_op_t           dec;
	pic_op_t           q_mem [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic [ADDR_W-1:0] a;
	logic [ADDR_W-1:0] rel_pend;
	logic [ADDR_W-1:0] rel_en;
	logic [ADDR_W-1:0] rel_ctx;
	logic              wr;

	assign a        = item.address;
	assign rel_pend = a - PEND_BASE;
	assign rel_en   = a - EN_BASE;
	assign rel_ctx  = a - CTX_BASE;
	assign wr       = (item.command == CMD_WRITE);

	always_comb begin
		dec.kind = OP_NOP;
		dec.idx  = '0;
		dec.ctx  = '0;
		dec.data = item.write_data;
		if (item.command == CMD_READ || item.command == CMD_WRITE) begin
			dec.kind = OP_ERR;
			if (a[1:0] == 2'b00) begin
				priority if (a < PRIO_END) begin
					dec.kind = wr ? OP_PRIO_WR : OP_PRIO_RD;
					dec.idx  = a[SRC_W+1:2];
				end else if (a >= PEND_BASE && a < PEND_END) begin
					dec.kind = wr ? OP_PEND_WR : OP_PEND_RD;
					dec.idx  = SRC_W'(rel_pend >> 2);
				end else if (a >= EN_BASE && a < EN_END) begin
					dec.ctx = CTX_W'(rel_en >> 8);
					dec.idx = SRC_W'(rel_en[7:2]);
					if (32'(rel_en[7:2]) < 32'(SRC_WORDS))
						dec.kind = wr ? OP_EN_WR : OP_EN_RD;
				end else if (a == CTRL_ADDR) begin
					dec.kind = wr ? OP_CTRL_WR : OP_CTRL_RD;
				end else if (a >= CTX_BASE && a < CTX_END) begin
					dec.ctx = CTX_W'(rel_ctx >> 13);
					if (rel_ctx[12:0] == 13'd0)
						dec.kind = wr ? OP_THR_WR : OP_THR_RD;
					else if (rel_ctx[12:0] == CLAIM_OFF)
						dec.kind = wr ? OP_COMPLETE : OP_CLAIM;
				end
			end
		end else if (item.command == CMD_REQUEST && item.level) begin
			dec.kind = OP_REQ;
			dec.data = 32'(item.source_id);
		end
	end

	assign busy  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign push  = start && !busy;
	assign head  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### src/pic_back.sv
// Back end: executes operations, scans sources for claims and interrupt lines.
module pic_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pic_pkg::pic_op_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              done,
	output pic_pkg::pic_res_t result
);
	import pic_pkg::*;

	pic_state_t                        state_q;
	pic_state_t                        state_d;
	pic_op_t                           op_q;
	logic                              claim_q;
	logic [31:0]                       rd_q;
	logic                              err_q;
	logic [SRC_W-1:0]                  scan_id_q;
	logic                              valid_s1;
	logic [SRC_W-1:0]                  id_s1;
	logic [PRIO_BITS-1:0]              prio_s1;
	logic                              pvld_s1;
	logic [NUM_CONTEXTS-1:0][SRC_W-1:0]     best_id_q;
	logic [NUM_CONTEXTS-1:0][PRIO_BITS-1:0] best_p_q;
	logic [PRIO_BITS-1:0]              prio_mem [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]            prio_vld_q;
	logic [NUM_SOURCES-1:0]            pend_q;
	logic [NUM_SOURCES-1:0]            insvc_q;
	logic [NUM_CONTEXTS-1:0][NUM_SOURCES-1:0] en_q;
	logic [NUM_CONTEXTS-1:0][PRIO_BITS-1:0]   thr_q;
	logic                              ctrl_q;
	logic                              done_q;
	pic_res_t                          result_q;

	logic                              exec;
	logic                              emit;
	logic                              claim_apply;
	logic                              mem_we;
	logic [SRC_W-1:0]                  rd_addr;
	logic [PRIO_BITS-1:0]              pv;
	logic [NUM_CONTEXTS-1:0]           cand;
	logic [NUM_CONTEXTS-1:0]           lines;
	logic [31:0]                       rd_val;
	logic [PRIO_BITS-1:0]              clamped;
	logic [SRC_W-1:0]                  cid;
	logic                              cid_ok;
	logic [SRC_W-1:0]                  bid;

	function automatic logic [31:0] word_bits(input logic [NUM_SOURCES-1:0] v,
			input logic [SRC_W-1:0] w);
		logic [31:0] r;
		int          id;
		r = '0;
		for (int b = 0; b < 32; b++) begin
			id = int'(w) * 32 + b;
			if (id >= 1 && id < NUM_SOURCES)
				r[b] = v[SRC_W'(id)];
		end
		return r;
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (!empty) state_d = ST_EXEC;
			ST_EXEC:   state_d = (op_q.kind == OP_PRIO_RD) ? ST_PRD : ST_SCAN;
			ST_PRD:    state_d = ST_SCAN;
			ST_SCAN:   if (scan_id_q == SRC_W'(NUM_SOURCES - 1)) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = claim_q ? ST_SCAN : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop         = (state_q == ST_IDLE) && !empty;
		exec        = (state_q == ST_EXEC);
		emit        = (state_q == ST_FINISH) && !claim_q;
		claim_apply = (state_q == ST_FINISH) && claim_q;
	end

	assign mem_we  = exec && op_q.kind == OP_PRIO_WR && op_q.idx != '0;
	assign rd_addr = (state_q == ST_SCAN) ? scan_id_q : op_q.idx;
	assign clamped = (op_q.data > PRIO_MAX) ? PRIO_MAX[PRIO_BITS-1:0]
		: op_q.data[PRIO_BITS-1:0];
	assign pv      = pvld_s1 ? prio_s1 : '0;
	assign cid     = op_q.data[SRC_W-1:0];
	assign cid_ok  = op_q.data >= 32'd1 && op_q.data < 32'(NUM_SOURCES);
	assign bid     = best_id_q[op_q.ctx];

	always_comb begin
		for (int c = 0; c < NUM_CONTEXTS; c++) begin
			cand[c]  = valid_s1 && id_s1 != '0 && pend_q[id_s1] && en_q[c][id_s1]
				&& pv > thr_q[c] && pv > best_p_q[c];
			lines[c] = best_id_q[c] != '0;
		end
	end

	always_comb begin
		unique case (op_q.kind)
			OP_PEND_RD: rd_val = word_bits(pend_q, op_q.idx);
			OP_EN_RD:   rd_val = word_bits(en_q[op_q.ctx], op_q.idx);
			OP_CTRL_RD: rd_val = {31'd0, ctrl_q};
			OP_THR_RD:  rd_val = 32'(thr_q[op_q.ctx]);
			default:    rd_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			prio_mem[op_q.idx] <= clamped;
		prio_s1 <= prio_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop)
			op_q <= head;
		id_s1 <= scan_id_q;
		if (emit) begin
			result_q.read_data    <= rd_q;
			result_q.access_error <= err_q;
			result_q.irq_lines    <= 4'(lines);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			claim_q    <= 1'b0;
			rd_q       <= '0;
			err_q      <= 1'b0;
			scan_id_q  <= '0;
			valid_s1   <= 1'b0;
			pvld_s1    <= 1'b0;
			best_id_q  <= '0;
			best_p_q   <= '0;
			prio_vld_q <= '0;
			pend_q     <= '0;
			insvc_q    <= '0;
			en_q       <= '0;
			thr_q      <= '0;
			ctrl_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= emit;
			valid_s1 <= (state_q == ST_SCAN);
			pvld_s1  <= prio_vld_q[rd_addr];
			if (pop)
				claim_q <= (head.kind == OP_CLAIM);

			if (state_q == ST_SCAN) begin
				scan_id_q <= (scan_id_q == SRC_W'(NUM_SOURCES - 1)) ? '0
					: scan_id_q + SRC_W'(1);
				if (scan_id_q == '0) begin
					best_id_q <= '0;
					best_p_q  <= '0;
				end
			end
			for (int c = 0; c < NUM_CONTEXTS; c++) begin
				if (cand[c]) begin
					best_id_q[c] <= id_s1;
					best_p_q[c]  <= pv;
				end
			end

			if (exec) begin
				rd_q  <= rd_val;
				err_q <= (op_q.kind == OP_ERR);
				unique case (op_q.kind)
					OP_PRIO_WR: if (op_q.idx != '0) prio_vld_q[op_q.idx] <= 1'b1;
					OP_PEND_WR: begin
						for (int i = 1; i < NUM_SOURCES; i++)
							if ((i >> 5) == int'(op_q.idx))
								pend_q[i] <= op_q.data[i & 31];
					end
					OP_EN_WR: begin
						for (int i = 1; i < NUM_SOURCES; i++)
							if ((i >> 5) == int'(op_q.idx))
								en_q[op_q.ctx][i] <= op_q.data[i & 31];
					end
					OP_CTRL_WR: ctrl_q <= op_q.data[0];
					OP_THR_WR:  thr_q[op_q.ctx] <= clamped;
					OP_COMPLETE: begin
						if (cid_ok && insvc_q[cid] && en_q[op_q.ctx][cid])
							insvc_q[cid] <= 1'b0;
					end
					OP_REQ: begin
						if (cid_ok && !insvc_q[cid])
							pend_q[cid] <= 1'b1;
					end
					default: ;
				endcase
			end

			if (state_q == ST_PRD)
				rd_q <= pvld_s1 ? 32'(prio_s1) : '0;

			if (claim_apply) begin
				claim_q <= 1'b0;
				rd_q    <= 32'(bid);
				if (bid != '0) begin
					pend_q[bid]  <= 1'b0;
					insvc_q[bid] <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/platform_interrupt_controller_core.sv
// Top level of the platform interrupt controller: front decode queue plus back end.
// The two-entry front queue takes new commands while the back end works; the back end
// takes one operation at a time from the queue and scans the sources one at a time,
// twice for a claim read, with an extra read step for a priority read. done strobes
// one cycle and cannot stall. Reset asynchronously clears the control and status
// state; the priority memory, queue storage and result register are not reset.
module platform_interrupt_controller_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pic_pkg::pic_cmd_t item,
	output logic              busy,
	output logic              done,
	output pic_pkg::pic_res_t result
);
	import pic_pkg::*;

	pic_op_t head;
	logic    empty;
	logic    pop;

	pic_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	pic_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule
